// ===== rtl/i2cbs_pkg.sv =====
// Package for the I2C master bit sequencer.
// It holds the command codes, sequencer phases, configuration indexes and the
// transaction types. It has no dependencies.
`default_nettype none
package i2cbs_pkg;

    localparam int UNIT_COUNTER_BITS = 10;
    localparam int UNIT_TICKS_W      = 10;
    localparam int POLL_W            = 8;
    localparam int BYTE_W            = 8;
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = 10;

    localparam logic [UNIT_TICKS_W-1:0] UNIT_TICKS_RESET     = UNIT_TICKS_W'(100);
    localparam logic [POLL_W-1:0]       ACK_POLL_LIMIT_RESET = POLL_W'(250);

    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_TICKS     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_POLL_LIMIT = CFG_INDEX_W'(1);

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_START    = 3'd1,
        ACT_STOP     = 3'd2,
        ACT_WRITE    = 3'd3,
        ACT_WAIT_ACK = 3'd4,
        ACT_READ     = 3'd5
    } action_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST_A = 5'd1,
        PH_ST_B = 5'd2,
        PH_SP_A = 5'd3,
        PH_SP_B = 5'd4,
        PH_WR_D = 5'd5,
        PH_WR_H = 5'd6,
        PH_WR_L = 5'd7,
        PH_WA_A = 5'd8,
        PH_WA_H = 5'd9,
        PH_WA_P = 5'd10,
        PH_RD_L = 5'd11,
        PH_RD_H = 5'd12,
        PH_AK_A = 5'd13,
        PH_AK_H = 5'd14
    } phase_t;

    typedef struct packed {
        action_t            cmd;
        logic [BYTE_W-1:0]  tx_byte;
        logic               send_ack;
        logic               sda_in;
    } tick_t;

    typedef struct packed {
        logic               scl_level;
        logic               sda_level;
        logic               sda_drive;
        logic               busy_res;
        logic               done_res;
        logic               ack_failed;
        logic [BYTE_W-1:0]  rx_byte;
    } line_t;

endpackage
`default_nettype wire

// ===== rtl/i2cbs_if.sv =====
// Channel interfaces of the I2C master bit sequencer.
// One carries input ticks, the other the resulting line levels; no dependencies.
`default_nettype none
interface i2cbs_tick_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, action, tx_byte, send_ack, sda_in, input ready);
    modport sink   (input valid, action, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cbs_line_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_failed;
    logic [7:0] rx_byte;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    ack_failed, rx_byte, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    ack_failed, rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2cbs_front.sv =====
// Front end: accepts tick transactions, classifies the action code and holds
// them in a two-entry queue. Depends on i2cbs_pkg and i2cbs_tick_if.
`default_nettype none
module i2cbs_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    i2cbs_tick_if.sink          tick,
    output i2cbs_pkg::tick_t    q_data,
    output logic                q_valid,
    input  wire logic           q_pop
);
    import i2cbs_pkg::*;

    tick_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    tick_t      classified;
    logic       push;

    always_comb
    begin
        classified.tx_byte  = tick.tx_byte;
        classified.send_ack = tick.send_ack;
        classified.sda_in   = tick.sda_in;
        if (tick.action <= ACT_READ)
        begin
            classified.cmd = action_t'(tick.action);
        end
        else
        begin
            classified.cmd = ACT_NONE;
        end
    end

    assign tick.ready = (count_reg != 2'd2);
    assign push       = tick.valid && tick.ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/i2cbs_back.sv =====
// Back end: the line sequencer state machine, configuration registers and the
// output register. It runs one queued tick per step. Depends on i2cbs_pkg.
`default_nettype none
module i2cbs_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [i2cbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [i2cbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire i2cbs_pkg::tick_t                   q_data,
    input  wire logic                               q_valid,
    output logic                                    q_pop,
    i2cbs_line_if.source                            line
);
    import i2cbs_pkg::*;

    phase_t                       phase_reg, phase_next;
    logic [2:0]                   bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0]            shift_reg, shift_next;
    logic [UNIT_COUNTER_BITS-1:0] unit_cnt_reg, unit_cnt_next;
    logic [2:0]                   units_left_reg, units_left_next;
    logic [POLL_W-1:0]            poll_reg, poll_next;
    logic                         ack_choice_reg, ack_choice_next;
    logic                         scl_reg, scl_next;
    logic                         sda_reg, sda_next;
    logic                         drive_reg, drive_next;
    logic [BYTE_W-1:0]            rx_hold_reg, rx_hold_next;
    logic                         fail_pending_reg, fail_pending_next;
    logic [UNIT_TICKS_W-1:0]      unit_ticks_reg;
    logic [POLL_W-1:0]            poll_limit_reg;
    logic                         out_valid_reg, out_valid_next;
    line_t                        out_reg, result;

    logic                         step;
    logic                         done_now;
    logic                         fail_now;
    logic [UNIT_TICKS_W-1:0]      ut_eff;
    logic [UNIT_COUNTER_BITS-1:0] cnt_inc;
    logic                         unit_hit;
    logic [2:0]                   units_dec;

    assign step    = q_valid && (!out_valid_reg || line.ready);
    assign q_pop   = step;
    assign ut_eff  = (unit_ticks_reg == '0) ? UNIT_TICKS_W'(1) : unit_ticks_reg;
    assign cnt_inc = unit_cnt_reg + UNIT_COUNTER_BITS'(1);
    assign unit_hit  = (17'(cnt_inc) >= 17'(ut_eff)) || (cnt_inc == '0);
    assign units_dec = (units_left_reg != 3'd0) ? units_left_reg - 3'd1 : 3'd0;

    always_comb
    begin
        phase_next        = phase_reg;
        bit_index_next    = bit_index_reg;
        shift_next        = shift_reg;
        unit_cnt_next     = unit_cnt_reg;
        units_left_next   = units_left_reg;
        poll_next         = poll_reg;
        ack_choice_next   = ack_choice_reg;
        scl_next          = scl_reg;
        sda_next          = sda_reg;
        drive_next        = drive_reg;
        rx_hold_next      = rx_hold_reg;
        fail_pending_next = fail_pending_reg;
        done_now          = 1'b0;
        fail_now          = 1'b0;

        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                bit_index_next    = 3'd0;
                poll_next         = '0;
                fail_pending_next = 1'b0;
                unique case (q_data.cmd)
                    ACT_START:
                    begin
                        scl_next = 1'b1; sda_next = 1'b1; drive_next = 1'b1;
                        phase_next = PH_ST_A; units_left_next = 3'd4; unit_cnt_next = '0;
                    end
                    ACT_STOP:
                    begin
                        scl_next = 1'b0; sda_next = 1'b0; drive_next = 1'b1;
                        phase_next = PH_SP_A; units_left_next = 3'd4; unit_cnt_next = '0;
                    end
                    ACT_WRITE:
                    begin
                        scl_next   = 1'b0;
                        drive_next = 1'b1;
                        sda_next   = q_data.tx_byte[BYTE_W-1];
                        shift_next = {q_data.tx_byte[BYTE_W-2:0], 1'b0};
                        phase_next = PH_WR_D; units_left_next = 3'd2; unit_cnt_next = '0;
                    end
                    ACT_WAIT_ACK:
                    begin
                        drive_next = 1'b0; sda_next = 1'b1;
                        phase_next = PH_WA_A; units_left_next = 3'd1; unit_cnt_next = '0;
                    end
                    ACT_READ:
                    begin
                        drive_next = 1'b0; sda_next = 1'b1; scl_next = 1'b0;
                        shift_next      = '0;
                        ack_choice_next = q_data.send_ack;
                        phase_next = PH_RD_L; units_left_next = 3'd2; unit_cnt_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (!unit_hit)
            begin
                unit_cnt_next = cnt_inc;
            end
            else
            begin
                unit_cnt_next   = '0;
                units_left_next = units_dec;
                if (units_dec == 3'd0)
                begin
                    unique case (phase_reg)
                        PH_ST_A:
                        begin
                            sda_next = 1'b0;
                            phase_next = PH_ST_B; units_left_next = 3'd4;
                        end
                        PH_ST_B:
                        begin
                            scl_next = 1'b0;
                            phase_next = PH_IDLE; done_now = 1'b1;
                        end
                        PH_SP_A:
                        begin
                            scl_next = 1'b1; sda_next = 1'b1;
                            phase_next = PH_SP_B; units_left_next = 3'd4;
                        end
                        PH_SP_B:
                        begin
                            phase_next = PH_IDLE; done_now = 1'b1;
                            fail_now = fail_pending_reg;
                            fail_pending_next = 1'b0;
                        end
                        PH_WR_D:
                        begin
                            scl_next = 1'b1;
                            phase_next = PH_WR_H; units_left_next = 3'd2;
                        end
                        PH_WR_H:
                        begin
                            scl_next = 1'b0;
                            phase_next = PH_WR_L; units_left_next = 3'd2;
                        end
                        PH_WR_L:
                        begin
                            if (bit_index_reg == 3'd7)
                            begin
                                phase_next = PH_IDLE; done_now = 1'b1;
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg + 3'd1;
                                sda_next   = shift_reg[BYTE_W-1];
                                shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                                phase_next = PH_WR_D; units_left_next = 3'd2;
                            end
                        end
                        PH_WA_A:
                        begin
                            scl_next = 1'b1;
                            phase_next = PH_WA_H; units_left_next = 3'd1;
                        end
                        PH_WA_H, PH_WA_P:
                        begin
                            if (!q_data.sda_in)
                            begin
                                scl_next = 1'b0;
                                phase_next = PH_IDLE; done_now = 1'b1;
                            end
                            else if (poll_reg >= poll_limit_reg)
                            begin
                                fail_pending_next = 1'b1;
                                scl_next = 1'b0; sda_next = 1'b0; drive_next = 1'b1;
                                phase_next = PH_SP_A; units_left_next = 3'd4;
                            end
                            else
                            begin
                                poll_next  = poll_reg + POLL_W'(1);
                                phase_next = PH_WA_P; units_left_next = 3'd1;
                            end
                        end
                        PH_RD_L:
                        begin
                            scl_next = 1'b1;
                            phase_next = PH_RD_H; units_left_next = 3'd1;
                        end
                        PH_RD_H:
                        begin
                            shift_next = {shift_reg[BYTE_W-2:0], q_data.sda_in};
                            scl_next   = 1'b0;
                            if (bit_index_reg == 3'd7)
                            begin
                                drive_next = 1'b1;
                                sda_next   = !ack_choice_reg;
                                phase_next = PH_AK_A; units_left_next = 3'd2;
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg + 3'd1;
                                phase_next = PH_RD_L; units_left_next = 3'd2;
                            end
                        end
                        PH_AK_A:
                        begin
                            scl_next = 1'b1;
                            phase_next = PH_AK_H; units_left_next = 3'd2;
                        end
                        PH_AK_H:
                        begin
                            scl_next     = 1'b0;
                            rx_hold_next = shift_reg;
                            phase_next   = PH_IDLE; done_now = 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE; done_now = 1'b1;
                        end
                    endcase
                    if (phase_next == PH_IDLE)
                    begin
                        units_left_next = 3'd0;
                    end
                end
            end
        end

        result.scl_level  = scl_next;
        result.sda_level  = drive_next ? sda_next : 1'b1;
        result.sda_drive  = drive_next;
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done_now;
        result.ack_failed = fail_now;
        result.rx_byte    = rx_hold_next;

        out_valid_next = step || (out_valid_reg && !line.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_index_reg    <= 3'd0;
            shift_reg        <= '0;
            unit_cnt_reg     <= '0;
            units_left_reg   <= 3'd0;
            poll_reg         <= '0;
            ack_choice_reg   <= 1'b0;
            scl_reg          <= 1'b1;
            sda_reg          <= 1'b1;
            drive_reg        <= 1'b1;
            rx_hold_reg      <= '0;
            fail_pending_reg <= 1'b0;
            unit_ticks_reg   <= UNIT_TICKS_RESET;
            poll_limit_reg   <= ACK_POLL_LIMIT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            bit_index_reg    <= bit_index_next;
            shift_reg        <= shift_next;
            unit_cnt_reg     <= unit_cnt_next;
            units_left_reg   <= units_left_next;
            poll_reg         <= poll_next;
            ack_choice_reg   <= ack_choice_next;
            scl_reg          <= scl_next;
            sda_reg          <= sda_next;
            drive_reg        <= drive_next;
            rx_hold_reg      <= rx_hold_next;
            fail_pending_reg <= fail_pending_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we && cfg_index == CFG_UNIT_TICKS)
            begin
                unit_ticks_reg <= cfg_wdata[UNIT_TICKS_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_ACK_POLL_LIMIT)
            begin
                poll_limit_reg <= cfg_wdata[POLL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign line.valid      = out_valid_reg;
    assign line.scl_level  = out_reg.scl_level;
    assign line.sda_level  = out_reg.sda_level;
    assign line.sda_drive  = out_reg.sda_drive;
    assign line.busy_res   = out_reg.busy_res;
    assign line.done_res   = out_reg.done_res;
    assign line.ack_failed = out_reg.ack_failed;
    assign line.rx_byte    = out_reg.rx_byte;

endmodule
`default_nettype wire

// ===== rtl/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer, top level.
// Depends on i2cbs_pkg, i2cbs_if, i2cbs_front and i2cbs_back.
//
// Each transaction on the tick channel is one tick of the bit sequencer. It
// carries the sampled SDA level and an action (start, stop, write byte, wait
// for ACK, read byte), which is taken only while no command is in progress.
// Every tick yields exactly one transaction on the line channel with the SCL
// level, the SDA level and output enable, busy, a one-tick done pulse, the
// ACK failure flag and the last received byte.
// Line timing is counted in delay units of unit_ticks ticks (register 0).
// The ACK wait polls SDA once per unit and issues a stop on the first
// high poll after ack_poll_limit high polls (register 1). Write registers
// only while idle. One tick is accepted every cycle while the queue has
// room. A tick enters a two-entry queue and, once popped, its result is
// registered in the output register. When the receiver stalls, the result
// is held, the queue fills, and the tick channel accepts at most two more
// ticks before it drops ready. Reset leaves SCL high, SDA high and driven,
// the sequencer idle, the queue empty and both registers at 100 and 250.
`default_nettype none
module i2c_master_bit_sequencer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [i2cbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [i2cbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    i2cbs_tick_if.sink                              tick,
    i2cbs_line_if.source                            line
);
    import i2cbs_pkg::*;

    tick_t q_data;
    logic  q_valid;
    logic  q_pop;

    i2cbs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    i2cbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_data    (q_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .line      (line)
    );

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        line.valid && line.done_res |-> !line.busy_res)
        else $error("Done reported while a command is still in progress.");

    a_fail_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        line.valid && line.ack_failed |-> line.done_res && line.sda_drive)
        else $error("ACK failure reported without a completed stop.");

    a_released_reads_high: assert property (@(posedge clk) disable iff (!rst_n)
        line.valid && !line.sda_drive |-> line.sda_level)
        else $error("Released SDA must read high.");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("Sequencer stepped without a queued tick.");

endmodule
`default_nettype wire

// ===== verif/i2cbs_line_checker.sv =====
// Checker for the I2C master bit sequencer: tracks register writes, predicts the
// line transaction of every tick and compares each field with the line channel.
// Depends on i2cbs_pkg and the channel interfaces in i2cbs_if.
`default_nettype none
module i2cbs_line_checker
    import i2cbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    i2cbs_tick_if                       tick,
    i2cbs_line_if                       line,
    output int                          errors,
    output logic                        seq_busy,
    output logic                        drained
);

    logic [UNIT_TICKS_W-1:0]      unit_ticks_cfg;
    logic [POLL_W-1:0]            poll_limit_cfg;
    phase_t                       ph;
    logic [2:0]                   bit_idx;
    logic [BYTE_W-1:0]            shreg;
    logic [UNIT_COUNTER_BITS-1:0] unit_cnt;
    logic [2:0]                   units_left;
    logic [POLL_W-1:0]            polls;
    logic                         ack_sel;
    logic                         scl_q;
    logic                         sda_q;
    logic                         drv_q;
    logic [BYTE_W-1:0]            rx_last;
    logic                         fail_armed;
    logic                         done_now;
    logic                         fail_now;
    line_t                        expected_lines[$];
    int                           fail_count;

    assign errors = fail_count;

    task automatic arm(input phase_t next, input logic [2:0] units);
        ph = next;
        units_left = units;
        unit_cnt = '0;
    endtask

    task automatic close_cmd();
        ph = PH_IDLE;
        units_left = '0;
        unit_cnt = '0;
        done_now = 1'b1;
    endtask

    task automatic shift_out();
        sda_q = shreg[7];
        shreg = shreg << 1;
    endtask

    task automatic step_line(input tick_t t, output line_t r);
        int span;
        done_now = 1'b0;
        fail_now = 1'b0;
        span = (unit_ticks_cfg == '0) ? 1 : int'(unit_ticks_cfg);
        if (ph == PH_IDLE)
        begin
            bit_idx = '0;
            polls = '0;
            fail_armed = 1'b0;
            case (t.cmd)
                ACT_START:
                begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                    drv_q = 1'b1;
                    arm(PH_ST_A, 3'd4);
                end
                ACT_STOP:
                begin
                    scl_q = 1'b0;
                    sda_q = 1'b0;
                    drv_q = 1'b1;
                    arm(PH_SP_A, 3'd4);
                end
                ACT_WRITE:
                begin
                    scl_q = 1'b0;
                    drv_q = 1'b1;
                    shreg = t.tx_byte;
                    shift_out();
                    arm(PH_WR_D, 3'd2);
                end
                ACT_WAIT_ACK:
                begin
                    drv_q = 1'b0;
                    sda_q = 1'b1;
                    arm(PH_WA_A, 3'd1);
                end
                ACT_READ:
                begin
                    drv_q = 1'b0;
                    sda_q = 1'b1;
                    scl_q = 1'b0;
                    shreg = '0;
                    ack_sel = t.send_ack;
                    arm(PH_RD_L, 3'd2);
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unit_cnt = unit_cnt + 1'b1;
            if (int'(unit_cnt) >= span || unit_cnt == '0)
            begin
                unit_cnt = '0;
                if (units_left != '0)
                    units_left = units_left - 1'b1;
                if (units_left == '0)
                begin
                    case (ph)
                        PH_ST_A:
                        begin
                            sda_q = 1'b0;
                            arm(PH_ST_B, 3'd4);
                        end
                        PH_ST_B:
                        begin
                            scl_q = 1'b0;
                            close_cmd();
                        end
                        PH_SP_A:
                        begin
                            scl_q = 1'b1;
                            sda_q = 1'b1;
                            arm(PH_SP_B, 3'd4);
                        end
                        PH_SP_B:
                        begin
                            close_cmd();
                            fail_now = fail_armed;
                            fail_armed = 1'b0;
                        end
                        PH_WR_D:
                        begin
                            scl_q = 1'b1;
                            arm(PH_WR_H, 3'd2);
                        end
                        PH_WR_H:
                        begin
                            scl_q = 1'b0;
                            arm(PH_WR_L, 3'd2);
                        end
                        PH_WR_L:
                        begin
                            if (bit_idx == 3'd7)
                                close_cmd();
                            else
                            begin
                                bit_idx = bit_idx + 1'b1;
                                shift_out();
                                arm(PH_WR_D, 3'd2);
                            end
                        end
                        PH_WA_A:
                        begin
                            scl_q = 1'b1;
                            arm(PH_WA_H, 3'd1);
                        end
                        PH_WA_H, PH_WA_P:
                        begin
                            if (!t.sda_in)
                            begin
                                scl_q = 1'b0;
                                close_cmd();
                            end
                            else if (polls >= poll_limit_cfg)
                            begin
                                // The slave never answered: release the bus with a stop.
                                fail_armed = 1'b1;
                                scl_q = 1'b0;
                                sda_q = 1'b0;
                                drv_q = 1'b1;
                                arm(PH_SP_A, 3'd4);
                            end
                            else
                            begin
                                polls = polls + 1'b1;
                                arm(PH_WA_P, 3'd1);
                            end
                        end
                        PH_RD_L:
                        begin
                            scl_q = 1'b1;
                            arm(PH_RD_H, 3'd1);
                        end
                        PH_RD_H:
                        begin
                            shreg = {shreg[BYTE_W-2:0], t.sda_in};
                            scl_q = 1'b0;
                            if (bit_idx == 3'd7)
                            begin
                                drv_q = 1'b1;
                                sda_q = !ack_sel;
                                arm(PH_AK_A, 3'd2);
                            end
                            else
                            begin
                                bit_idx = bit_idx + 1'b1;
                                arm(PH_RD_L, 3'd2);
                            end
                        end
                        PH_AK_A:
                        begin
                            scl_q = 1'b1;
                            arm(PH_AK_H, 3'd2);
                        end
                        PH_AK_H:
                        begin
                            scl_q = 1'b0;
                            rx_last = shreg;
                            close_cmd();
                        end
                        default:
                            close_cmd();
                    endcase
                end
            end
        end
        r.scl_level = scl_q;
        r.sda_level = drv_q ? sda_q : 1'b1;
        r.sda_drive = drv_q;
        r.busy_res = (ph != PH_IDLE);
        r.done_res = done_now;
        r.ack_failed = fail_now;
        r.rx_byte = rx_last;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tick_t t;
        line_t want;
        line_t got;
        if (!rst_n)
        begin
            unit_ticks_cfg = UNIT_TICKS_RESET;
            poll_limit_cfg = ACK_POLL_LIMIT_RESET;
            ph = PH_IDLE;
            bit_idx = '0;
            shreg = '0;
            unit_cnt = '0;
            units_left = '0;
            polls = '0;
            ack_sel = 1'b0;
            scl_q = 1'b1;
            sda_q = 1'b1;
            drv_q = 1'b1;
            rx_last = '0;
            fail_armed = 1'b0;
            done_now = 1'b0;
            fail_now = 1'b0;
            fail_count = 0;
            expected_lines.delete();
            seq_busy <= 1'b0;
            drained <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_UNIT_TICKS)
                    unit_ticks_cfg = cfg_wdata[UNIT_TICKS_W-1:0];
                else
                    poll_limit_cfg = cfg_wdata[POLL_W-1:0];
            end
            if (tick.valid && tick.ready)
            begin
                t.cmd = action_t'(tick.action);
                t.tx_byte = tick.tx_byte;
                t.send_ack = tick.send_ack;
                t.sda_in = tick.sda_in;
                step_line(t, want);
                expected_lines.push_back(want);
            end
            if (line.valid && line.ready)
            begin
                got.scl_level = line.scl_level;
                got.sda_level = line.sda_level;
                got.sda_drive = line.sda_drive;
                got.busy_res = line.busy_res;
                got.done_res = line.done_res;
                got.ack_failed = line.ack_failed;
                got.rx_byte = line.rx_byte;
                if (expected_lines.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected no line transaction, actual %h", $time, got);
                end
                else
                begin
                    want = expected_lines.pop_front();
                    check_field("scl_level", want.scl_level, got.scl_level);
                    check_field("sda_level", want.sda_level, got.sda_level);
                    check_field("sda_drive", want.sda_drive, got.sda_drive);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("ack_failed", want.ack_failed, got.ack_failed);
                    check_field("rx_byte", want.rx_byte, got.rx_byte);
                end
            end
            seq_busy <= (ph != PH_IDLE);
            drained <= (expected_lines.size() == 0);
        end
    end

endmodule
`default_nettype wire

// ===== verif/i2c_master_bit_sequencer_test.sv =====
// Top of the I2C master bit sequencer test: clock, reset, register writes, tick
// stimulus with bursts and gaps, a stalling line receiver, watchdog and verdict.
// Depends on i2cbs_pkg, i2cbs_if, the sequencer RTL and i2cbs_line_checker.
`default_nettype none
module i2c_master_bit_sequencer_test
    import i2cbs_pkg::*;
();

    localparam logic [2:0] ACT_SPARE_6  = 3'd6;
    localparam logic [2:0] ACT_SPARE_7  = 3'd7;
    localparam int         RANDOM_TICKS = 100;
    localparam int         HOLD_EVERY   = 500;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 5000;
    localparam int         DRAIN_CYCLES = 10;

    typedef enum {SDA_LOW, SDA_HIGH, SDA_NOISE} sda_mode_e;
    typedef enum {RX_FREE, RX_PATTERN, RX_RANDOM} rx_mode_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    int                     errors;
    logic                   seq_busy;
    logic                   drained;
    int                     idle_cycles = 0;
    int unsigned            unit_set[6] = '{1, 2, 1, 1, 3, 1};
    int unsigned            limit_set[6] = '{1, 0, 7, 3, 255, 2};

    i2cbs_tick_if tick_ch();
    i2cbs_line_if line_ch();

    i2c_master_bit_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tick      (tick_ch),
        .line      (line_ch)
    );

    i2cbs_line_checker i_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tick      (tick_ch),
        .line      (line_ch),
        .errors    (errors),
        .seq_busy  (seq_busy),
        .drained   (drained)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (line_ch.valid && line_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic sda_for(input sda_mode_e mode);
        if (mode == SDA_NOISE)
            return 1'($urandom_range(1));
        return (mode == SDA_HIGH);
    endfunction

    task automatic offer(input logic [2:0] act, input logic [7:0] data, input logic ack,
                         input logic sda);
        tick_ch.valid <= 1'b1;
        tick_ch.action <= act;
        tick_ch.tx_byte <= data;
        tick_ch.send_ack <= ack;
        tick_ch.sda_in <= sda;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
    endtask

    task automatic configure(input int unsigned ticks_per_unit, input int unsigned poll_limit);
        cfg_we <= 1'b1;
        cfg_index <= CFG_UNIT_TICKS;
        cfg_wdata <= CFG_DATA_W'(ticks_per_unit);
        @(posedge clk);
        cfg_index <= CFG_ACK_POLL_LIMIT;
        cfg_wdata <= CFG_DATA_W'(poll_limit);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Feed idle ticks until the command in flight completes, then let every
    // expected line transaction arrive.
    task automatic run_out(input sda_mode_e mode);
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (seq_busy)
            offer(ACT_NONE, 8'h00, 1'b0, sda_for(mode));
        tick_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (!drained);
    endtask

    task automatic issue_command(input logic [2:0] act, input logic [7:0] data, input logic ack,
                                 input sda_mode_e mode);
        offer(act, data, ack, sda_for(mode));
        if (act inside {ACT_START, ACT_STOP, ACT_WRITE, ACT_WAIT_ACK, ACT_READ})
            offer((act == ACT_READ) ? ACT_WRITE : ACT_READ, ~data, ~ack, sda_for(mode));
        run_out(mode);
    endtask

    task automatic stream_ticks(input int count);
        int left;
        int burst;
        int gap;
        int run;
        int roll;
        logic level;
        logic [2:0] act;
        left = count;
        run = 0;
        level = 1'b1;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0)
            begin
                if (run == 0)
                begin
                    level = 1'($urandom_range(1));
                    run = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(10, 60);
                end
                run--;
                roll = $urandom_range(19);
                if (roll < 17)
                    act = 3'($urandom_range(ACT_START, ACT_READ));
                else if (roll == 17)
                    act = ACT_NONE;
                else if (roll == 18)
                    act = ACT_SPARE_6;
                else
                    act = ACT_SPARE_7;
                offer(act, 8'($urandom_range(255)), 1'($urandom_range(1)), level);
                burst--;
                left--;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && left > 0)
            begin
                tick_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin : receiver
        int seg;
        int period;
        int since_hold;
        int k;
        rx_mode_e mode;
        line_ch.ready <= 1'b0;
        since_hold = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (since_hold >= HOLD_EVERY)
            begin
                line_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                since_hold = 0;
            end
            mode = rx_mode_e'($urandom_range(2));
            seg = $urandom_range(20, 120);
            period = $urandom_range(2, 6);
            for (k = 0; k < seg; k++)
            begin
                case (mode)
                    RX_FREE:    line_ch.ready <= 1'b1;
                    RX_PATTERN: line_ch.ready <= ((k % period) != 0);
                    default:    line_ch.ready <= 1'($urandom_range(1));
                endcase
                @(posedge clk);
            end
            since_hold += seg;
        end
    end

    initial
    begin : stimulus
        int i;
        tick_ch.valid <= 1'b0;
        tick_ch.action <= ACT_NONE;
        tick_ch.tx_byte <= 8'h00;
        tick_ch.send_ack <= 1'b0;
        tick_ch.sda_in <= 1'b1;
        cfg_we <= 1'b0;
        cfg_index <= CFG_UNIT_TICKS;
        cfg_wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_command(ACT_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);

        configure(1, 2);
        issue_command(ACT_START, 8'h00, 1'b0, SDA_NOISE);
        issue_command(ACT_WRITE, 8'hFF, 1'b1, SDA_NOISE);
        issue_command(ACT_WRITE, 8'h00, 1'b0, SDA_NOISE);
        issue_command(ACT_WRITE, 8'h80, 1'b0, SDA_NOISE);
        issue_command(ACT_WRITE, 8'h01, 1'b1, SDA_NOISE);
        issue_command(ACT_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);
        issue_command(ACT_WAIT_ACK, 8'hFF, 1'b1, SDA_HIGH);
        issue_command(ACT_READ, 8'h00, 1'b1, SDA_NOISE);
        issue_command(ACT_READ, 8'h00, 1'b0, SDA_HIGH);
        issue_command(ACT_READ, 8'hFF, 1'b1, SDA_LOW);
        issue_command(ACT_STOP, 8'h5A, 1'b1, SDA_NOISE);
        issue_command(ACT_NONE, 8'hA5, 1'b1, SDA_NOISE);
        issue_command(ACT_SPARE_6, 8'hFF, 1'b1, SDA_NOISE);
        issue_command(ACT_SPARE_7, 8'hFF, 1'b1, SDA_NOISE);

        // Zero ticks per unit counts as one; a zero poll limit fails on the first high poll.
        configure(0, 0);
        issue_command(ACT_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH);
        issue_command(ACT_WAIT_ACK, 8'h00, 1'b0, SDA_LOW);

        configure(1, 255);
        issue_command(ACT_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH);

        for (i = 0; i < 6; i++)
        begin
            configure(unit_set[i], limit_set[i]);
            stream_ticks(RANDOM_TICKS);
            run_out(SDA_NOISE);
        end

        configure(12, 1);
        issue_command(ACT_START, 8'h00, 1'b0, SDA_NOISE);
        issue_command(ACT_STOP, 8'h00, 1'b0, SDA_NOISE);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/i2cbs_pkg.sv
rtl/i2cbs_if.sv
rtl/i2cbs_front.sv
rtl/i2cbs_back.sv
rtl/i2c_master_bit_sequencer.sv
verif/i2cbs_line_checker.sv
verif/i2c_master_bit_sequencer_test.sv
